### rtl/rmq_pkg.sv
// rmq_pkg: types, widths and codes for the matrix to quaternion block
// no dependencies
`timescale 1ns / 1ps

package rmq_pkg;

   localparam int DataWidth = 16;
   localparam int FracBits  = DataWidth - 2;
   localparam int VecWidth  = DataWidth + 3;        // signed radicand / vector entry
   localparam int MagWidth  = VecWidth - 1;          // magnitude of a vector entry
   localparam int SumWidth  = 2 * MagWidth + 2;      // sum of four squares
   localparam int RootWidth = SumWidth / 2;          // floor sqrt of the sum
   localparam int NumWidth  = MagWidth + FracBits;   // dividend of the normalize step
   localparam int MinWidth  = 15;
   localparam int DivSteps  = NumWidth + 1;          // one quotient bit per stage

   typedef enum logic [1:0] {
      BR_TRACE = 2'd0,
      BR_X     = 2'd1,
      BR_Y     = 2'd2,
      BR_Z     = 2'd3
   } branch_type;

   typedef struct packed {
      logic signed [DataWidth-1:0] m00;
      logic signed [DataWidth-1:0] m01;
      logic signed [DataWidth-1:0] m02;
      logic signed [DataWidth-1:0] m10;
      logic signed [DataWidth-1:0] m11;
      logic signed [DataWidth-1:0] m12;
      logic signed [DataWidth-1:0] m20;
      logic signed [DataWidth-1:0] m21;
      logic signed [DataWidth-1:0] m22;
   } req_word_type;

   typedef struct packed {
      logic signed [DataWidth-1:0] qx;
      logic signed [DataWidth-1:0] qy;
      logic signed [DataWidth-1:0] qz;
      logic signed [DataWidth-1:0] qw;
      logic                        degenerate;
      logic [1:0]                  branch_used;
   } rsp_word_type;

   // classified work handed from front to back
   typedef struct packed {
      logic [3:0]               neg;
      logic [3:0][MagWidth-1:0] mag;
      logic [SumWidth-1:0]      sum;
      logic                     degenerate;
      branch_type               branch;
   } job_type;

endpackage

### rtl/rmq_front.sv
// rmq_front: branch selection, vector forming, sum of squares, length check
// depends on rmq_pkg
`timescale 1ns / 1ps

module rmq_front
   import rmq_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_stall,
   input  req_word_type        in_word,
   input  logic [MinWidth-1:0] min_length,
   output logic                out_valid,
   input  logic                out_stall,
   output job_type             out_job
);

   localparam int CmpWidth = SumWidth + 28;

   logic                         v1_ff, v1_in, v2_ff, v2_in, v3_ff, v3_in;
   logic                         adv1, adv2, adv3;
   branch_type                   br1_ff, br1_in, br2_ff, br3_ff;
   logic signed [VecWidth-1:0]   r1_ff, r1_in;
   logic [3:0]                   ng1_ff, ng1_in, ng2_ff, ng3_ff;
   logic [3:0][MagWidth-1:0]     mg1_ff, mg1_in, mg2_ff, mg3_ff;
   logic [3:0][SumWidth-1:0]     sq2_ff, sq2_in;
   logic [SumWidth-1:0]          s3_ff, s3_in;
   logic [2*MinWidth-1:0]        ml2_ff, ml2_in;
   logic [MagWidth-1:0]          rm2_ff;
   logic                         rbad2_ff, rbad2_in;
   logic [MagWidth+2*MinWidth-1:0] rhs3_ff, rhs3_in;
   logic                         rbad3_ff;
   logic signed [VecWidth-1:0]   m [9];
   logic signed [VecWidth-1:0]   vv [4];
   logic signed [VecWidth-1:0]   one;
   logic [CmpWidth-1:0]          lhs, rhs;

   assign adv3 = !v3_ff || !out_stall;
   assign adv2 = !v2_ff || adv3;
   assign adv1 = !v1_ff || adv2;
   assign in_stall = !adv1;

   assign m[0] = VecWidth'(in_word.m00);
   assign m[1] = VecWidth'(in_word.m01);
   assign m[2] = VecWidth'(in_word.m02);
   assign m[3] = VecWidth'(in_word.m10);
   assign m[4] = VecWidth'(in_word.m11);
   assign m[5] = VecWidth'(in_word.m12);
   assign m[6] = VecWidth'(in_word.m20);
   assign m[7] = VecWidth'(in_word.m21);
   assign m[8] = VecWidth'(in_word.m22);
   assign one  = VecWidth'(1) <<< FracBits;

   // stage 1: pick branch and form the vector
   always_comb begin
      if (m[0] + m[4] + m[8] > 0) begin
         br1_in = BR_TRACE;
         r1_in  = one + m[0] + m[4] + m[8];
         vv[0] = m[7] - m[5]; vv[1] = m[2] - m[6]; vv[2] = m[3] - m[1]; vv[3] = r1_in;
      end else if (m[0] > m[4] && m[0] > m[8]) begin
         br1_in = BR_X;
         r1_in  = one + m[0] - m[4] - m[8];
         vv[0] = r1_in; vv[1] = m[1] + m[3]; vv[2] = m[2] + m[6]; vv[3] = m[7] - m[5];
      end else if (m[4] > m[8]) begin
         br1_in = BR_Y;
         r1_in  = one + m[4] - m[0] - m[8];
         vv[0] = m[1] + m[3]; vv[1] = r1_in; vv[2] = m[5] + m[7]; vv[3] = m[2] - m[6];
      end else begin
         br1_in = BR_Z;
         r1_in  = one + m[8] - m[0] - m[4];
         vv[0] = m[2] + m[6]; vv[1] = m[5] + m[7]; vv[2] = r1_in; vv[3] = m[3] - m[1];
      end
      for (int i = 0; i < 4; i++) begin
         ng1_in[i] = vv[i][VecWidth-1];
         mg1_in[i] = vv[i][VecWidth-1] ? MagWidth'(-vv[i]) : MagWidth'(vv[i]);
      end
   end

   // stage 2: squares and the radicand sign check
   always_comb begin
      for (int i = 0; i < 4; i++) begin
         sq2_in[i] = SumWidth'(mg1_ff[i]) * SumWidth'(mg1_ff[i]);
      end
      ml2_in   = (2*MinWidth)'(min_length) * (2*MinWidth)'(min_length);
      rbad2_in = (r1_ff <= 0);
   end

   // stage 3: sum and min length product
   always_comb begin
      s3_in   = sq2_ff[0] + sq2_ff[1] + sq2_ff[2] + sq2_ff[3];
      rhs3_in = (MagWidth+2*MinWidth)'(rm2_ff) * (MagWidth+2*MinWidth)'(ml2_ff);
   end

   assign lhs = CmpWidth'(s3_ff) << 28;
   assign rhs = CmpWidth'(rhs3_ff) << DataWidth;

   assign v1_in = adv1 ? in_valid : v1_ff;
   assign v2_in = adv2 ? v1_ff : v2_ff;
   assign v3_in = adv3 ? v2_ff : v3_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv1) begin
         br1_ff <= br1_in;
         r1_ff  <= r1_in;
         ng1_ff <= ng1_in;
         mg1_ff <= mg1_in;
      end
      if (adv2) begin
         br2_ff   <= br1_ff;
         ng2_ff   <= ng1_ff;
         mg2_ff   <= mg1_ff;
         sq2_ff   <= sq2_in;
         ml2_ff   <= ml2_in;
         rm2_ff   <= MagWidth'(r1_ff);
         rbad2_ff <= rbad2_in;
      end
      if (adv3) begin
         br3_ff   <= br2_ff;
         ng3_ff   <= ng2_ff;
         mg3_ff   <= mg2_ff;
         s3_ff    <= s3_in;
         rhs3_ff  <= rhs3_in;
         rbad3_ff <= rbad2_ff;
      end
   end

   assign out_valid          = v3_ff;
   assign out_job.neg        = ng3_ff;
   assign out_job.mag        = mg3_ff;
   assign out_job.sum        = s3_ff;
   assign out_job.branch     = br3_ff;
   // a zero sum also fails here whenever min_length is nonzero; the back checks the root
   assign out_job.degenerate = rbad3_ff || (lhs < rhs);

endmodule

### rtl/rmq_queue.sv
// rmq_queue: two entry queue between front and back
// depends on rmq_pkg
`timescale 1ns / 1ps

module rmq_queue
   import rmq_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   output logic    in_stall,
   input  job_type in_job,
   output logic    out_valid,
   input  logic    out_stall,
   output job_type out_job
);

   job_type    mem_ff [2];
   logic       wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       push, pop;

   assign in_stall  = (cnt_ff == 2'd2);
   assign out_valid = (cnt_ff != 2'd0);
   assign out_job   = mem_ff[rp_ff];
   assign push      = in_valid && !in_stall;
   assign pop       = out_valid && !out_stall;
   assign wp_in     = push ? !wp_ff : wp_ff;
   assign rp_in     = pop ? !rp_ff : rp_ff;
   assign cnt_in    = cnt_ff + 2'(push) - 2'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wp_ff] <= in_job;
      end
   end

endmodule

### rtl/rmq_back.sv
// rmq_back: pipelined square root, four pipelined dividers, saturation
// depends on rmq_pkg
`timescale 1ns / 1ps

module rmq_back
   import rmq_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         in_valid,
   output logic         in_stall,
   input  job_type      in_job,
   output logic         out_valid,
   input  logic         out_stall,
   output rsp_word_type out_word
);

   localparam int SqSteps = RootWidth;
   localparam int Stages  = SqSteps + DivSteps + 1;
   localparam int RemW    = RootWidth + 2;
   localparam int QW      = NumWidth + 1;

   logic                  vld_ff [Stages+1];
   logic                  adv [Stages+1];
   job_type               job_ff [Stages+1];
   // root pipeline
   logic [SumWidth-1:0]   rem_ff [SqSteps+1];
   logic [RootWidth-1:0]  rt_ff [SqSteps+1];
   // divide pipeline, per lane
   logic [3:0][NumWidth-1:0] num_ff [DivSteps+1];
   logic [3:0][RemW-1:0]     drem_ff [DivSteps+1];
   logic [3:0][QW-1:0]       quo_ff [DivSteps+1];
   logic [RootWidth-1:0]     den_ff [DivSteps+1];
   rsp_word_type          res_ff;
   logic                  res_v_ff;

   assign adv[Stages] = !res_v_ff || !out_stall;
   for (genvar g = Stages - 1; g >= 0; g--) begin : g_adv
      assign adv[g] = !vld_ff[g+1] || adv[g+1];
   end
   assign in_stall = !adv[0];

   assign vld_ff[0] = in_valid;
   assign job_ff[0] = in_job;
   assign rem_ff[0] = in_job.sum;
   assign rt_ff[0]  = '0;

   // square root, one bit per stage, msb first
   for (genvar k = 0; k < SqSteps; k++) begin : g_sqrt
      localparam int B = SqSteps - 1 - k;
      logic [SumWidth-1:0] trial;
      logic [SumWidth-1:0] rem_n;
      logic [RootWidth-1:0] rt_n;
      logic [SumWidth:0]    tw;
      always_comb begin
         tw    = ((SumWidth+1)'(rt_ff[k]) << (B + 1)) + ((SumWidth+1)'(1) << (2 * B));
         trial = SumWidth'(tw);
         if (tw <= (SumWidth+1)'(rem_ff[k])) begin
            rem_n = rem_ff[k] - trial;
            rt_n  = rt_ff[k] | (RootWidth'(1) << B);
         end else begin
            rem_n = rem_ff[k];
            rt_n  = rt_ff[k];
         end
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k+1] <= 1'b0;
         end else if (adv[k]) begin
            vld_ff[k+1] <= vld_ff[k];
         end
      end
      always_ff @(posedge clock) begin
         if (adv[k]) begin
            job_ff[k+1] <= job_ff[k];
            rem_ff[k+1] <= rem_n;
            rt_ff[k+1]  <= rt_n;
         end
      end
   end

   // dividend with rounding: mag << F + len/2, divisor len
   always_comb begin
      for (int i = 0; i < 4; i++) begin
         num_ff[0][i]  = (NumWidth'(job_ff[SqSteps].mag[i]) << FracBits)
                         + NumWidth'(rt_ff[SqSteps] >> 1);
         drem_ff[0][i] = '0;
         quo_ff[0][i]  = '0;
      end
      den_ff[0] = rt_ff[SqSteps];
   end

   // restoring divide, one quotient bit per stage
   for (genvar k = 0; k < DivSteps; k++) begin : g_div
      localparam int S = SqSteps + k;
      localparam int B = DivSteps - 1 - k;
      logic [3:0][RemW-1:0] dr_n;
      logic [3:0][QW-1:0]   q_n;
      logic [RemW-1:0]      t;
      always_comb begin
         for (int i = 0; i < 4; i++) begin
            if (B < NumWidth) begin
               t = {drem_ff[k][i][RemW-2:0], num_ff[k][i][B % NumWidth]};
            end else begin
               t = {drem_ff[k][i][RemW-2:0], 1'b0};
            end
            if (t >= RemW'(den_ff[k])) begin
               dr_n[i] = t - RemW'(den_ff[k]);
               q_n[i]  = quo_ff[k][i] | (QW'(1) << B);
            end else begin
               dr_n[i] = t;
               q_n[i]  = quo_ff[k][i];
            end
         end
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[S+1] <= 1'b0;
         end else if (adv[S]) begin
            vld_ff[S+1] <= vld_ff[S];
         end
      end
      always_ff @(posedge clock) begin
         if (adv[S]) begin
            job_ff[S+1]  <= job_ff[S];
            num_ff[k+1]  <= num_ff[k];
            drem_ff[k+1] <= dr_n;
            quo_ff[k+1]  <= q_n;
            den_ff[k+1]  <= den_ff[k];
         end
      end
   end

   // saturate and pick identity
   localparam int L = Stages - 1;
   job_type      jl;
   rsp_word_type res_in;
   logic [DataWidth-1:0] qo [4];
   assign jl = job_ff[L];
   always_comb begin
      for (int i = 0; i < 4; i++) begin
         if (quo_ff[DivSteps][i] > QW'((1 << (DataWidth - 1)) - 1)) begin
            qo[i] = jl.neg[i] ? {1'b1, {(DataWidth-1){1'b0}}}
                              : {1'b0, {(DataWidth-1){1'b1}}};
         end else begin
            qo[i] = jl.neg[i] ? DataWidth'(-quo_ff[DivSteps][i])
                              : DataWidth'(quo_ff[DivSteps][i]);
         end
      end
      res_in.branch_used = jl.branch;
      if (jl.degenerate || den_ff[DivSteps] == '0) begin
         res_in.qx = '0;
         res_in.qy = '0;
         res_in.qz = '0;
         res_in.qw = DataWidth'(1) << FracBits;
         res_in.degenerate = 1'b1;
      end else begin
         res_in.qx = qo[0];
         res_in.qy = qo[1];
         res_in.qz = qo[2];
         res_in.qw = qo[3];
         res_in.degenerate = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         res_v_ff <= 1'b0;
      end else if (adv[Stages]) begin
         res_v_ff <= vld_ff[L];
      end
   end

   always_ff @(posedge clock) begin
      if (adv[Stages]) begin
         res_ff <= res_in;
      end
   end

   assign vld_ff[Stages] = res_v_ff;
   assign job_ff[Stages] = job_ff[L];
   assign out_valid = res_v_ff;
   assign out_word  = res_ff;

endmodule

### rtl/rotation_matrix_to_quaternion.sv
// rotation_matrix_to_quaternion: top level, front, queue and back joined
// depends on rmq_pkg, rmq_front, rmq_queue, rmq_back
`timescale 1ns / 1ps
//
// takes one 3x3 rotation matrix per req word (nine signed Q2.14 entries) and
// returns one rsp word: the unit quaternion by the Shepperd method, a degenerate
// flag and the branch that was used
// req: req_valid / req_stall, word taken when valid and not stalled
// rsp: rsp_valid / rsp_stall, same rule; the block holds the word while stalled
// csr: csr_valid / csr_ready write of min_length (15 bits, reset 1), always ready
// throughput: one matrix per cycle while rsp_stall is low; the front pipeline (3 stages),
// a 2 entry queue, a bit-per-stage square root (19 stages) and bit-per-stage dividers
// (33 stages) lie in that order between the req port and the output register that
// drives rsp_valid
// a rsp stall backs up stage by stage; req_stall rises only when all are full
// reset empties every stage and the queue and sets min_length to 1
//
module rotation_matrix_to_quaternion
   import rmq_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  req_word_type        req_word,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output rsp_word_type        rsp_word,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [MinWidth-1:0] csr_data
);

   logic [MinWidth-1:0] min_len_ff, min_len_in;
   logic    f_valid, f_stall, b_valid, b_stall;
   job_type f_job, b_job;

   assign csr_ready  = 1'b1;
   assign min_len_in = csr_valid ? csr_data : min_len_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_len_ff <= MinWidth'(1);
      end else begin
         min_len_ff <= min_len_in;
      end
   end

   rmq_front u_front (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_valid),
      .in_stall   (req_stall),
      .in_word    (req_word),
      .min_length (min_len_ff),
      .out_valid  (f_valid),
      .out_stall  (f_stall),
      .out_job    (f_job)
   );

   rmq_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (f_valid),
      .in_stall  (f_stall),
      .in_job    (f_job),
      .out_valid (b_valid),
      .out_stall (b_stall),
      .out_job   (b_job)
   );

   rmq_back u_back (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (b_valid),
      .in_stall  (b_stall),
      .in_job    (b_job),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_word  (rsp_word)
   );

endmodule

### bench/rotation_matrix_to_quaternion_tb.sv
// rotation_matrix_to_quaternion_tb: randomized self-checking bench for the
// matrix to quaternion block; depends on rmq_pkg and rotation_matrix_to_quaternion
`timescale 1ns / 1ps

class quat_scoreboard;
   rmq_pkg::rsp_word_type pending[$];
   int unsigned mismatches;
   logic [14:0] min_len;

   function new();
      mismatches = 0;
      min_len = 15'd1;
   endfunction

   // floor square root of a wide sum, bit by bit
   function automatic longint unsigned isqrt(logic [127:0] s);
      logic [127:0] c;
      longint unsigned res;
      res = 0;
      for (int b = 36; b >= 0; b--) begin
         c = 128'(res | (64'd1 << b));
         if (!(s < c * c)) res = 64'(c);
      end
      return res;
   endfunction

   function automatic logic signed [15:0] clamp(longint v);
      if (v > 32767) return 16'sh7fff;
      if (v < -32768) return 16'sh8000;
      return v[15:0];
   endfunction

   // works out the quaternion for an accepted matrix word
   function void note_matrix(rmq_pkg::req_word_type w);
      rmq_pkg::rsp_word_type q;
      longint m00, m01, m02, m10, m11, m12, m20, m21, m22, r, one;
      longint v[4];
      longint unsigned mg, len, quo;
      logic [127:0] s, lhs, rhs;
      rmq_pkg::branch_type br;
      one = 64'sd1 << 14;
      m00 = longint'(w.m00); m01 = longint'(w.m01); m02 = longint'(w.m02);
      m10 = longint'(w.m10); m11 = longint'(w.m11); m12 = longint'(w.m12);
      m20 = longint'(w.m20); m21 = longint'(w.m21); m22 = longint'(w.m22);
      if (m00 + m11 + m22 > 0) begin
         br = rmq_pkg::BR_TRACE; r = one + m00 + m11 + m22;
         v[0] = m21 - m12; v[1] = m02 - m20; v[2] = m10 - m01; v[3] = r;
      end else if (m00 > m11 && m00 > m22) begin
         br = rmq_pkg::BR_X; r = one + m00 - m11 - m22;
         v[0] = r; v[1] = m01 + m10; v[2] = m02 + m20; v[3] = m21 - m12;
      end else if (m11 > m22) begin
         br = rmq_pkg::BR_Y; r = one + m11 - m00 - m22;
         v[0] = m01 + m10; v[1] = r; v[2] = m12 + m21; v[3] = m02 - m20;
      end else begin
         br = rmq_pkg::BR_Z; r = one + m22 - m00 - m11;
         v[0] = m02 + m20; v[1] = m12 + m21; v[2] = r; v[3] = m10 - m01;
      end
      q.qx = '0; q.qy = '0; q.qz = '0; q.qw = clamp(one);
      q.degenerate = 1'b1;
      q.branch_used = br;
      if (r > 0) begin
         s = '0;
         for (int i = 0; i < 4; i++) begin
            mg = (v[i] < 0) ? -v[i] : v[i];
            s += 128'(mg) * 128'(mg);
         end
         lhs = s << 28;
         rhs = (128'(r) * 128'(min_len) * 128'(min_len)) << 16;
         len = isqrt(s);
         if (!(lhs < rhs) && len != 0) begin
            longint res[4];
            for (int i = 0; i < 4; i++) begin
               mg = (v[i] < 0) ? -v[i] : v[i];
               quo = ((mg << 14) + (len >> 1)) / len;
               if (quo > 64'd2147483647) quo = 64'd2147483647;
               res[i] = (v[i] < 0) ? -longint'(quo) : longint'(quo);
            end
            q.qx = clamp(res[0]); q.qy = clamp(res[1]);
            q.qz = clamp(res[2]); q.qw = clamp(res[3]);
            q.degenerate = 1'b0;
         end
      end
      pending.push_back(q);
   endfunction

   function void check_quat(rmq_pkg::rsp_word_type got);
      rmq_pkg::rsp_word_type exp_q;
      if (pending.size() == 0) begin
         mismatches++;
         if (mismatches <= 10) $display("unexpected word %h", got);
         return;
      end
      exp_q = pending.pop_front();
      if (got !== exp_q) begin
         mismatches++;
         if (mismatches <= 10)
            $display({"mismatch: expected q=(%0d %0d %0d %0d) deg %b br %0d,",
                      " got (%0d %0d %0d %0d) deg %b br %0d"},
                     exp_q.qx, exp_q.qy, exp_q.qz, exp_q.qw, exp_q.degenerate,
                     exp_q.branch_used, got.qx, got.qy, got.qz, got.qw,
                     got.degenerate, got.branch_used);
      end
   endfunction
endclass

module rotation_matrix_to_quaternion_tb;
   import rmq_pkg::*;

   localparam int WatchLimit = 5000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_word_type req_word = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_word_type rsp_word;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [MinWidth-1:0] csr_data = '0;

   quat_scoreboard board = new();
   bit calm = 1'b0;   // stretch with no idling on either side
   int unsigned quiet_cycles = 0;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   rotation_matrix_to_quaternion dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_word(req_word),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_word(rsp_word),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   // result side: check every accepted word, stall at random
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) board.check_quat(rsp_word);
      rsp_stall <= calm ? 1'b0 : ($urandom_range(99) < 16);
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || reset)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WatchLimit) begin
         $display("watchdog expired");
         $display("== FAIL ==");
         $finish;
      end
   end

   // valid stays high between back to back words; idle cycles drop it
   task automatic send_matrix(req_word_type w);
      while (!calm && $urandom_range(99) < 16) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_word <= w;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      board.note_matrix(w);
   endtask

   task automatic write_min_length(logic [MinWidth-1:0] val);
      csr_valid <= 1'b1;
      csr_data <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      board.min_len = val;
      csr_valid <= 1'b0;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (80) @(posedge clock);
   endtask

   function automatic req_word_type diag(int a, int b, int c);
      req_word_type w;
      w = '0;
      w.m00 = 16'(a); w.m11 = 16'(b); w.m22 = 16'(c);
      return w;
   endfunction

   function automatic logic signed [15:0] jitter(int base, int span);
      return 16'(base + int'($urandom_range(2 * span)) - span);
   endfunction

   // rotation-like matrix: strong diagonal with small random coupling
   function automatic req_word_type near_rotation();
      req_word_type w;
      int d;
      w = '0;
      d = int'($urandom_range(3));
      w.m00 = jitter((d == 0 || d == 1) ? 16384 : -16384, 2000);
      w.m11 = jitter((d == 0 || d == 2) ? 16384 : -16384, 2000);
      w.m22 = jitter((d == 0 || d == 3) ? 16384 : -16384, 2000);
      w.m01 = jitter(0, 8000); w.m10 = jitter(0, 8000);
      w.m02 = jitter(0, 8000); w.m20 = jitter(0, 8000);
      w.m12 = jitter(0, 8000); w.m21 = jitter(0, 8000);
      return w;
   endfunction

   initial begin
      req_word_type w;
      logic [MinWidth-1:0] settings[4];
      logic [159:0] rnd;
      settings = '{15'd0, 15'd32767, 15'd16384, 15'd1};
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: identity, each branch, ties, extremes, degenerate radicand
      send_matrix(diag(16384, 16384, 16384));
      send_matrix(diag(16384, -16384, -16384));
      send_matrix(diag(-16384, 16384, -16384));
      send_matrix(diag(-16384, -16384, 16384));
      send_matrix(diag(0, 0, 0));
      send_matrix(diag(-100, -100, -200));
      send_matrix(diag(-32768, -32768, -32768));
      send_matrix(diag(32767, -32768, -32768));
      send_matrix(diag(-16384, -16384, -16384));
      send_matrix(diag(-20000, -20000, -20000));
      send_matrix({9{16'sh7fff}});
      send_matrix({9{16'sh8000}});
      w = diag(-32768, 32767, -32768); w.m01 = 16'sh7fff; w.m10 = 16'sh7fff;
      send_matrix(w);
      w = diag(32767, 32767, 32767); w.m21 = 16'sh8000; w.m12 = 16'sh7fff;
      send_matrix(w);
      w = diag(1, 0, 0); send_matrix(w);
      w = diag(-16384, -16384, 0); w.m02 = 16'sh8000; w.m20 = 16'sh8000;
      send_matrix(w);
      drain();

      for (int ph = 0; ph < 4; ph++) begin
         write_min_length(settings[ph]);
         send_matrix(diag(-16383, -16383, -16383));
         send_matrix(diag(16384, 16384, 16384));
         calm = (ph == 2);
         for (int n = 0; n < 110; n++) begin
            if ($urandom_range(9) < 7) begin
               w = near_rotation();
            end else begin
               rnd = {$urandom, $urandom, $urandom, $urandom, $urandom};
               w = rnd[143:0];
            end
            send_matrix(w);
         end
         calm = 1'b0;
         drain();
      end

      if (board.mismatches == 0 && board.pending.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end
endmodule

### filelist.f
rtl/rmq_pkg.sv
rtl/rmq_front.sv
rtl/rmq_queue.sv
rtl/rmq_back.sv
rtl/rotation_matrix_to_quaternion.sv
bench/rotation_matrix_to_quaternion_tb.sv
